[rtl/size_weighted_lru_cache_assert.svh]
// Assertion macros for the cache RTL.
`ifndef SIZE_WEIGHTED_LRU_CACHE_ASSERT_SVH
`define SIZE_WEIGHTED_LRU_CACHE_ASSERT_SVH

// Same-cycle implication under synchronous active-low reset.
`define SWLRU_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define SWLRU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/swlru_pkg.sv]
`timescale 1ns / 1ps

package swlru_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned USED_W  = 33;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [1:0] {
        KIND_HIT      = 2'd0,
        KIND_INSERTED = 2'd1,
        KIND_FAILED   = 2'd2,
        KIND_EVICTED  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SEARCH_CMP,
        ST_HIT,
        ST_MISS,
        ST_EVICT_CHECK,
        ST_EVICT_FIND,
        ST_EVICT_EMIT,
        ST_FREE_FIND,
        ST_INSERT
    } state_t;

    typedef enum logic [1:0] {
        RK_NONE,
        RK_PROMOTE,
        RK_INSERT,
        RK_EVICT
    } rank_op_t;

endpackage

[rtl/swlru_mem.sv]
`timescale 1ns / 1ps

module swlru_mem #(
    parameter int ENTRIES = 16,
    parameter int KEY_W   = 32
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [$clog2(ENTRIES)-1:0]  wr_addr,
    input  logic [KEY_W-1:0]            wr_key,
    input  logic [swlru_pkg::DATA_W-1:0] wr_size,
    input  logic [$clog2(ENTRIES)-1:0]  rd_addr,
    output logic [KEY_W-1:0]            rd_key,
    output logic [swlru_pkg::DATA_W-1:0] rd_size
);

    logic [KEY_W-1:0]             key_mem  [ENTRIES];
    logic [swlru_pkg::DATA_W-1:0] size_mem [ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr]  <= wr_key;
            size_mem[wr_addr] <= wr_size;
        end
        rd_key  <= key_mem[rd_addr];
        rd_size <= size_mem[rd_addr];
    end

endmodule

[rtl/swlru_rank.sv]
`timescale 1ns / 1ps

module swlru_rank #(
    parameter int ENTRIES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  swlru_pkg::rank_op_t          op,
    input  logic [$clog2(ENTRIES)-1:0]   idx,
    output logic                         probe_valid,
    output logic [$clog2(ENTRIES)-1:0]   probe_rank
);

    localparam int RANK_W = $clog2(ENTRIES);

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [RANK_W-1:0]  rank_reg  [ENTRIES];
    logic [RANK_W-1:0]  rank_next [ENTRIES];
    logic [RANK_W-1:0]  sel_rank;

    assign sel_rank    = rank_reg[idx];
    assign probe_valid = valid_reg[idx];
    assign probe_rank  = sel_rank;

    always_comb begin
        valid_next = valid_reg;
        for (int j = 0; j < ENTRIES; j++) begin
            rank_next[j] = rank_reg[j];
        end
        case (op)
            swlru_pkg::RK_PROMOTE: begin
                // age everything more recent than the hit entry
                for (int j = 0; j < ENTRIES; j++) begin
                    if (valid_reg[j] && rank_reg[j] < sel_rank) begin
                        rank_next[j] = rank_reg[j] + 1'b1;
                    end
                end
                rank_next[idx] = '0;
            end
            swlru_pkg::RK_INSERT: begin
                for (int j = 0; j < ENTRIES; j++) begin
                    if (valid_reg[j]) begin
                        rank_next[j] = rank_reg[j] + 1'b1;
                    end
                end
                rank_next[idx]  = '0;
                valid_next[idx] = 1'b1;
            end
            swlru_pkg::RK_EVICT: begin
                valid_next[idx] = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int j = 0; j < ENTRIES; j++) begin
                rank_reg[j] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            for (int j = 0; j < ENTRIES; j++) begin
                rank_reg[j] <= rank_next[j];
            end
        end
    end

endmodule

[rtl/size_weighted_lru_cache.sv]
// Flow: the accept edge starts a serial key search that skips an empty slot and reads, then
// compares, a valid one; a hit or a load failure (zero size) then loads the result register.
// A miss with a size runs each eviction as check, oldest-rank scan and emit, then the insert
// as check, free-slot scan and write. One request at a time: s_ready is low from accept
// until the state returns to idle after the last beat; a beat waits while m_ready is low and
// the result register is full. Reset: aresetn synchronous, active low; clears control state, not payload or memory.
`timescale 1ns / 1ps

module size_weighted_lru_cache #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // budget register
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_key,
    input  logic [31:0] s_object_bytes,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_result_key,
    output logic [31:0] m_result_bytes,
    output logic        m_last,
    output logic [32:0] m_used_bytes,
    output logic [4:0]  m_entry_count,
    output logic [31:0] m_request_count,
    output logic [31:0] m_hit_count
);

    `include "size_weighted_lru_cache_assert.svh"

    // Stored key width: only the low KEY_BITS of the 32-bit port take part.
    localparam int KEY_W = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    swlru_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [31:0]       size_reg, size_next;
    logic [31:0]       budget_reg, budget_next;
    logic [32:0]       total_reg, total_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       req_reg, req_next;
    logic [31:0]       hits_reg, hits_next;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] rkey_reg, rkey_next;
    logic [31:0] rbytes_reg, rbytes_next;
    logic        last_reg, last_next;
    logic [32:0] used_reg, used_next;
    logic [4:0]  ecount_reg, ecount_next;
    logic [31:0] rreq_reg, rreq_next;
    logic [31:0] rhits_reg, rhits_next;

    logic                 out_free;
    logic                 emit_fire;
    logic                 mem_we;
    logic [KEY_W-1:0]     mem_key;
    logic [31:0]          mem_size;
    logic                 probe_valid;
    logic [IDX_W-1:0]     probe_rank;
    swlru_pkg::rank_op_t  rank_op;
    logic [33:0]          need_bytes;

    swlru_mem #(
        .ENTRIES (ENTRIES),
        .KEY_W   (KEY_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (idx_reg),
        .wr_key  (key_reg),
        .wr_size (size_reg),
        .rd_addr (idx_reg),
        .rd_key  (mem_key),
        .rd_size (mem_size)
    );

    swlru_rank #(
        .ENTRIES (ENTRIES)
    ) u_rank (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (rank_op),
        .idx         (idx_reg),
        .probe_valid (probe_valid),
        .probe_rank  (probe_rank)
    );

    // The result register frees when empty or when its beat is taken this cycle.
    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == swlru_pkg::ST_IDLE);
    assign need_bytes = {1'b0, total_reg} + {2'b00, size_reg};

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        key_next     = key_reg;
        size_next    = size_reg;
        budget_next  = cfg_wr_en ? cfg_wr_data : budget_reg;
        total_next   = total_reg;
        count_next   = count_reg;
        req_next     = req_reg;
        hits_next    = hits_reg;
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        rkey_next    = rkey_reg;
        rbytes_next  = rbytes_reg;
        last_next    = last_reg;
        used_next    = used_reg;
        ecount_next  = ecount_reg;
        rreq_next    = rreq_reg;
        rhits_next   = rhits_reg;
        emit_fire    = 1'b0;
        mem_we       = 1'b0;
        rank_op      = swlru_pkg::RK_NONE;

        case (state_reg)
            swlru_pkg::ST_IDLE: begin
                if (s_valid) begin
                    key_next   = s_key[KEY_W-1:0];
                    size_next  = s_object_bytes;
                    req_next   = req_reg + 32'd1;
                    idx_next   = '0;
                    state_next = swlru_pkg::ST_SEARCH;
                end
            end
            swlru_pkg::ST_SEARCH: begin
                // skip empty slots; a valid one waits for its registered key read
                if (probe_valid) begin
                    state_next = swlru_pkg::ST_SEARCH_CMP;
                end else if (idx_reg == LAST_IDX) begin
                    state_next = swlru_pkg::ST_MISS;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            swlru_pkg::ST_SEARCH_CMP: begin
                if (mem_key == key_reg) begin
                    state_next = swlru_pkg::ST_HIT;
                end else if (idx_reg == LAST_IDX) begin
                    state_next = swlru_pkg::ST_MISS;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = swlru_pkg::ST_SEARCH;
                end
            end
            swlru_pkg::ST_HIT: begin
                if (out_free) begin
                    emit_fire   = 1'b1;
                    rank_op     = swlru_pkg::RK_PROMOTE;
                    hits_next   = hits_reg + 32'd1;
                    kind_next   = swlru_pkg::KIND_HIT;
                    rbytes_next = mem_size;
                    last_next   = 1'b1;
                    used_next   = total_reg;
                    ecount_next = 5'(count_reg);
                    rhits_next  = hits_reg + 32'd1;
                    state_next  = swlru_pkg::ST_IDLE;
                end
            end
            swlru_pkg::ST_MISS: begin
                if (size_reg == 32'd0) begin
                    if (out_free) begin
                        emit_fire   = 1'b1;
                        kind_next   = swlru_pkg::KIND_FAILED;
                        rbytes_next = 32'd0;
                        last_next   = 1'b1;
                        used_next   = total_reg;
                        ecount_next = 5'(count_reg);
                        rhits_next  = hits_reg;
                        state_next  = swlru_pkg::ST_IDLE;
                    end
                end else begin
                    state_next = swlru_pkg::ST_EVICT_CHECK;
                end
            end
            swlru_pkg::ST_EVICT_CHECK: begin
                // over budget with something to drop, or table full: evict oldest
                idx_next = '0;
                if ((count_reg != '0 && need_bytes > {2'b00, budget_reg}) ||
                    count_reg >= FULL_CNT) begin
                    state_next = swlru_pkg::ST_EVICT_FIND;
                end else begin
                    state_next = swlru_pkg::ST_FREE_FIND;
                end
            end
            swlru_pkg::ST_EVICT_FIND: begin
                if (probe_valid && CNT_W'(probe_rank) == count_reg - 1'b1) begin
                    state_next = swlru_pkg::ST_EVICT_EMIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            swlru_pkg::ST_EVICT_EMIT: begin
                if (out_free) begin
                    emit_fire   = 1'b1;
                    rank_op     = swlru_pkg::RK_EVICT;
                    total_next  = total_reg - {1'b0, mem_size};
                    count_next  = count_reg - 1'b1;
                    kind_next   = swlru_pkg::KIND_EVICTED;
                    rkey_next   = 32'(mem_key);
                    rbytes_next = mem_size;
                    last_next   = 1'b0;
                    used_next   = total_reg - {1'b0, mem_size};
                    ecount_next = 5'(count_reg - 1'b1);
                    rhits_next  = hits_reg;
                    state_next  = swlru_pkg::ST_EVICT_CHECK;
                end
            end
            swlru_pkg::ST_FREE_FIND: begin
                if (!probe_valid) begin
                    state_next = swlru_pkg::ST_INSERT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            swlru_pkg::ST_INSERT: begin
                if (out_free) begin
                    emit_fire   = 1'b1;
                    mem_we      = 1'b1;
                    rank_op     = swlru_pkg::RK_INSERT;
                    total_next  = need_bytes[32:0];
                    count_next  = count_reg + 1'b1;
                    kind_next   = swlru_pkg::KIND_INSERTED;
                    rbytes_next = size_reg;
                    last_next   = 1'b1;
                    used_next   = need_bytes[32:0];
                    ecount_next = 5'(count_reg + 1'b1);
                    rhits_next  = hits_reg;
                    state_next  = swlru_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swlru_pkg::ST_IDLE;
            end
        endcase

        if (emit_fire) begin
            m_valid_next = 1'b1;
            rreq_next    = req_reg;
            if (state_reg != swlru_pkg::ST_EVICT_EMIT) begin
                rkey_next = 32'(key_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swlru_pkg::ST_IDLE;
            idx_reg     <= '0;
            budget_reg  <= '0;
            total_reg   <= '0;
            count_reg   <= '0;
            req_reg     <= '0;
            hits_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            budget_reg  <= budget_next;
            total_reg   <= total_next;
            count_reg   <= count_next;
            req_reg     <= req_next;
            hits_reg    <= hits_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload holds; no reset needed
    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        size_reg   <= size_next;
        kind_reg   <= kind_next;
        rkey_reg   <= rkey_next;
        rbytes_reg <= rbytes_next;
        last_reg   <= last_next;
        used_reg   <= used_next;
        ecount_reg <= ecount_next;
        rreq_reg   <= rreq_next;
        rhits_reg  <= rhits_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_kind          = kind_reg;
    assign m_result_key    = rkey_reg;
    assign m_result_bytes  = rbytes_reg;
    assign m_last          = last_reg;
    assign m_used_bytes    = used_reg;
    assign m_entry_count   = ecount_reg;
    assign m_request_count = rreq_reg;
    assign m_hit_count     = rhits_reg;

    `SWLRU_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= FULL_CNT, "entry count overflow")
    `SWLRU_ASSERT_NOW(a_evict_nonempty, aclk, aresetn, state_reg == swlru_pkg::ST_EVICT_EMIT && emit_fire, count_reg != '0, "eviction from empty table")
    `SWLRU_ASSERT_NOW(a_insert_room, aclk, aresetn, state_reg == swlru_pkg::ST_INSERT && emit_fire, count_reg < FULL_CNT && !probe_valid, "insert into occupied slot")
    `SWLRU_ASSERT_NEXT(a_accept_search, aclk, aresetn, s_valid && s_ready, state_reg == swlru_pkg::ST_SEARCH, "accepted request did not start search")

endmodule
